/* design/itrd_pkg.sv */
// ============================================================================
// itrd_pkg: shared types and constants for the radix digit converter
// Holds the controller state type, the command and status bundles between
// controller and datapath, the ASCII constants and the digit encoder.
// ============================================================================
package itrd_pkg;

    localparam int DATA_IN_W     = 72;
    localparam int DATA_OUT_W    = 8;
    localparam int RADIX_W       = 6;
    localparam int DIGIT_W       = 6;
    localparam int CHAR_W        = 7;
    localparam int DIV_STEP_BITS = 4;

    localparam int FIELD_VALUE_LSB  = 0;
    localparam int FIELD_RADIX_LSB  = 64;
    localparam int FIELD_SIGNED_BIT = 70;
    localparam int FIELD_UPPER_BIT  = 71;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO      = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_OFS = 7'h37;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_OFS = 7'h57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS     = 7'h2D;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE    = 6'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIVIDE,
        ST_MINUS,
        ST_FETCH,
        ST_PUSH
    } itrd_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic store;
        logic out_minus;
        logic out_digit;
        logic ptr_dec;
    } itrd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic quot_zero;
        logic minus;
        logic ptr_zero;
        logic out_free;
    } itrd_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] ofs;
        if (d > DIGIT_NINE) begin
            ofs = upper ? CHAR_UPPER_OFS : CHAR_LOWER_OFS;
        end else begin
            ofs = CHAR_ZERO;
        end
        return CHAR_W'(ofs + CHAR_W'(d));
    endfunction

endpackage

/* design/itrd_div.sv */
// ============================================================================
// itrd_div: iterative divider by a small base
// Restoring division of a padded magnitude by a 6-bit base, a few quotient
// bits per cycle. The quotient replaces the dividend in the shift register.
// ============================================================================
module itrd_div
    import itrd_pkg::*;
#(
    parameter int PAD_W = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [PAD_W-1:0]     dividend,
    input  logic [RADIX_W-1:0]   divisor,
    output logic                 done,
    output logic [PAD_W-1:0]     quotient,
    output logic [DIGIT_W-1:0]   remainder
);

    localparam int NumSteps = PAD_W / DIV_STEP_BITS;
    localparam int CntW     = $clog2(NumSteps + 1);

    logic [PAD_W-1:0]   sh_reg,   sh_next;
    logic [DIGIT_W:0]   rem_reg,  rem_next;
    logic [RADIX_W-1:0] div_reg;
    logic [CntW-1:0]    cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIGIT_W:0]   trial;

    // Each pass shifts one dividend bit into the partial remainder and
    // subtracts the base where it fits; the remainder stays below the base.
    always_comb begin
        sh_next  = sh_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            trial   = {rem_next[DIGIT_W-1:0], sh_next[PAD_W-1]};
            sh_next = {sh_next[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                trial      = trial - {1'b0, div_reg};
                sh_next[0] = 1'b1;
            end
            rem_next = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CntW'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(NumSteps);
            end else if (busy_reg) begin
                cnt_reg  <= cnt_reg - CntW'(1);
                busy_reg <= (cnt_reg != CntW'(1));
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = sh_reg;
    assign remainder = rem_reg[DIGIT_W-1:0];

    a_start_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg)
        else $error("divider did not start");

    a_done_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider reported done while still busy");

endmodule

/* design/itrd_dpath.sv */
// ============================================================================
// itrd_dpath: datapath of the radix digit converter
// Forms the magnitude and clamped base, runs the divider, keeps the digit
// store and drives the output character register.
// ============================================================================
module itrd_dpath
    import itrd_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  itrd_cmd_t             cmd,
    output itrd_status_t          status,
    input  logic [DATA_IN_W-1:0]  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAR_W-1:0]     out_char,
    output logic                  out_last
);

    localparam int PadW =
        ((VALUE_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
    localparam int IdxW = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] in_value;
    logic [RADIX_W-1:0]     in_radix;
    logic                   in_negative;
    logic [VALUE_WIDTH-1:0] in_magnitude;
    logic [RADIX_W-1:0]     base_next;

    logic [PadW-1:0]        mag_reg;
    logic [RADIX_W-1:0]     base_reg;
    logic                   upper_reg;
    logic                   minus_reg;
    logic [IdxW-1:0]        wr_ptr_reg;
    logic [IdxW-1:0]        rd_ptr_reg;
    logic [DIGIT_W-1:0]     rd_data_reg;
    logic [DIGIT_W-1:0]     digit_mem [VALUE_WIDTH];

    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      out_char_reg;
    logic                   out_last_reg;

    logic                   div_done;
    logic [PadW-1:0]        div_quot;
    logic [DIGIT_W-1:0]     div_rem;

    assign in_value     = in_data[FIELD_VALUE_LSB +: VALUE_WIDTH];
    assign in_radix     = in_data[FIELD_RADIX_LSB +: RADIX_W];
    assign in_negative  = in_data[FIELD_SIGNED_BIT] && in_value[VALUE_WIDTH-1];
    // The most negative value negates onto itself, which is its magnitude.
    assign in_magnitude = in_negative ? VALUE_WIDTH'(~in_value + 1'b1) : in_value;

    always_comb begin
        if (in_radix < RADIX_MIN) begin
            base_next = RADIX_MIN;
        end else if (in_radix > RADIX_MAX) begin
            base_next = RADIX_MAX;
        end else begin
            base_next = in_radix;
        end
    end

    itrd_div #(
        .PAD_W (PadW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (mag_reg),
        .divisor   (base_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg   <= PadW'(in_magnitude);
            base_reg  <= base_next;
            upper_reg <= in_data[FIELD_UPPER_BIT];
        end else if (cmd.store) begin
            mag_reg <= div_quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            digit_mem[wr_ptr_reg] <= div_rem;
        end
        rd_data_reg <= digit_mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minus_reg  <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (cmd.load) begin
                minus_reg  <= in_negative && (base_next == RADIX_DECIMAL);
                wr_ptr_reg <= '0;
            end else if (cmd.store) begin
                wr_ptr_reg <= wr_ptr_reg + IdxW'(1);
            end
            if (cmd.store) begin
                rd_ptr_reg <= wr_ptr_reg;
            end else if (cmd.ptr_dec) begin
                rd_ptr_reg <= rd_ptr_reg - IdxW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_minus || cmd.out_digit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_minus) begin
            out_char_reg <= CHAR_MINUS;
            out_last_reg <= 1'b0;
        end else if (cmd.out_digit) begin
            out_char_reg <= digit_char(rd_data_reg, upper_reg);
            out_last_reg <= (rd_ptr_reg == '0);
        end
    end

    assign status.div_done  = div_done;
    assign status.quot_zero = (div_quot == '0);
    assign status.minus     = minus_reg;
    assign status.ptr_zero  = (rd_ptr_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    a_out_load : assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_minus || cmd.out_digit) |=> out_valid_reg)
        else $error("output register not loaded");

endmodule

/* design/itrd_ctrl.sv */
// ============================================================================
// itrd_ctrl: controller of the radix digit converter
// Sequences input transfer, one division per digit, the optional minus sign
// and the read-back of the stored digits, most significant first.
// ============================================================================
module itrd_ctrl
    import itrd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  itrd_status_t  status,
    output itrd_cmd_t     cmd
);

    itrd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    cmd.store = 1'b1;
                    if (!status.quot_zero) begin
                        state_next = ST_START;
                    end else if (status.minus) begin
                        state_next = ST_MINUS;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_MINUS: begin
                if (status.out_free) begin
                    cmd.out_minus = 1'b1;
                    state_next    = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // The digit store read takes this cycle.
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.out_digit = 1'b1;
                    if (status.ptr_zero) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.ptr_dec = 1'b1;
                        state_next  = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_start : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_START))
        else $error("accepted transfer did not start a division");

    a_out_free : assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_digit || cmd.out_minus) |-> status.out_free)
        else $error("output register overwritten");

endmodule

/* design/integer_to_radix_digits.sv */
// ============================================================================
// integer_to_radix_digits: ASCII digits of an integer in base 2 to 36
// Digits: each digit takes one division in the shared divider, which retires
//   four quotient bits a cycle.
// Transfers: a new transfer is taken only once the last character of the
//   previous one is in the output register; each digit is read back through
//   the digit store read and the output register.
// Reset: aresetn clears the controller, pointers and output valid; the
//   digit store is not cleared, each conversion writes before it reads.
// ============================================================================
module integer_to_radix_digits
    import itrd_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // value_bits[63:0], radix[69:64], is_signed[70], upper_case[71]
    input  logic [DATA_IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // character[6:0], zero[7]
    output logic [DATA_OUT_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    itrd_cmd_t         cmd;
    itrd_status_t      status;
    logic [CHAR_W-1:0] out_char;

    itrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itrd_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (out_char),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = DATA_OUT_W'(out_char);

endmodule

/* sim/itrd_checker.sv */
// ============================================================================
// itrd_checker: scoreboard for the radix digit converter
// Watches both stream channels. Every accepted conversion request is turned
// into the characters it must produce, and every character transfer on the
// result side is compared with the oldest one still awaited.
// ============================================================================
module itrd_checker
    import itrd_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // value_bits[63:0], radix[69:64], is_signed[70], upper_case[71]
    input  logic [DATA_IN_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // character[6:0], zero[7]
    input  logic [DATA_OUT_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tlast,
    output int                    failures,
    output int                    chars_outstanding
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } char_exp_t;

    char_exp_t awaited_chars[$];
    int        fail_tally = 0;

    function automatic logic [CHAR_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
        logic [7:0] c;
        if (d < 10) begin
            c = "0" + 8'(d);
        end else if (upper) begin
            c = "A" + 8'(d) - 8'd10;
        end else begin
            c = "a" + 8'(d) - 8'd10;
        end
        return c[CHAR_W-1:0];
    endfunction

    // Works out the full character string of one conversion request.
    function automatic void predict_chars(input logic [DATA_IN_W-1:0] word);
        logic [63:0]        mask;
        logic [63:0]        mag;
        logic [63:0]        base;
        logic [DIGIT_W-1:0] digits[64];
        logic               upper;
        bit                 with_minus;
        int                 count;
        int                 k;
        mask  = {64{1'b1}} >> (64 - VALUE_WIDTH);
        mag   = word[FIELD_VALUE_LSB +: 64] & mask;
        base  = 64'(word[FIELD_RADIX_LSB +: RADIX_W]);
        upper = word[FIELD_UPPER_BIT];
        if (base < 64'(RADIX_MIN)) begin
            base = 64'(RADIX_MIN);
        end
        if (base > 64'(RADIX_MAX)) begin
            base = 64'(RADIX_MAX);
        end
        with_minus = 1'b0;
        if (word[FIELD_SIGNED_BIT] && mag[VALUE_WIDTH-1]) begin
            mag = (~mag + 64'd1) & mask;
            // The most negative value has no positive twin at this width.
            if (mag == 64'd0) begin
                mag = 64'd1 << (VALUE_WIDTH - 1);
            end
            with_minus = (base == 64'(RADIX_DECIMAL));
        end
        count = 0;
        do begin
            digits[count] = DIGIT_W'(mag % base);
            mag = mag / base;
            count++;
        end while (mag != 64'd0 && count < 64);
        if (with_minus) begin
            awaited_chars.push_back('{CHAR_MINUS, 1'b0});
        end
        for (k = count - 1; k >= 0; k--) begin
            awaited_chars.push_back('{glyph_of(digits[k], upper), k == 0});
        end
    endfunction

    always @(posedge aclk) begin
        char_exp_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_chars.size() == 0) begin
                    $error("unexpected character transfer: data %h, last %b",
                           m_axis_tdata, m_axis_tlast);
                    fail_tally++;
                end else begin
                    want = awaited_chars.pop_front();
                    if (m_axis_tdata[CHAR_W-1:0] !== want.ch) begin
                        $error("character: expected %h, got %h",
                               want.ch, m_axis_tdata[CHAR_W-1:0]);
                        fail_tally++;
                    end
                    if (m_axis_tlast !== want.is_last) begin
                        $error("last_char: expected %b, got %b",
                               want.is_last, m_axis_tlast);
                        fail_tally++;
                    end
                    if (m_axis_tdata[DATA_OUT_W-1:CHAR_W] !== '0) begin
                        $error("pad bits: expected %h, got %h", 1'b0,
                               m_axis_tdata[DATA_OUT_W-1:CHAR_W]);
                        fail_tally++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_chars(s_axis_tdata);
            end
        end
        failures          <= fail_tally;
        chars_outstanding <= awaited_chars.size();
    end

endmodule

/* sim/tb_integer_to_radix_digits.sv */
// ============================================================================
// tb_integer_to_radix_digits: testbench for the radix digit converter
// Sends a directed set of corner conversions followed by random requests,
// with random gaps on the request side and random back-pressure on the
// character side. A separate scoreboard predicts and checks every character.
// ============================================================================
module tb_integer_to_radix_digits;
    import itrd_pkg::*;

    localparam int VALUE_WIDTH  = 64;
    localparam int RANDOM_ITEMS = 236;
    // One 64-digit conversion plus the final character, with some margin.
    localparam int DRAIN_CYCLES = 1500;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_IN_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_OUT_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    int                    failures;
    int                    chars_outstanding;
    bit                    src_calm = 1'b0;

    always #5 aclk = ~aclk;

    integer_to_radix_digits #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    itrd_checker #(.VALUE_WIDTH(VALUE_WIDTH)) checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tlast      (m_axis_tlast),
        .failures          (failures),
        .chars_outstanding (chars_outstanding)
    );

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DATA_IN_W-1:0] pack_request(input logic [63:0] value,
                                                          input logic [RADIX_W-1:0] radix,
                                                          input logic is_signed,
                                                          input logic upper_case);
        logic [DATA_IN_W-1:0] word;
        word = '0;
        word[FIELD_VALUE_LSB +: 64]     = value;
        word[FIELD_RADIX_LSB +: RADIX_W] = radix;
        word[FIELD_SIGNED_BIT]           = is_signed;
        word[FIELD_UPPER_BIT]            = upper_case;
        return word;
    endfunction

    // Presents one request and returns at the edge where it is taken.
    task automatic send_request(input logic [DATA_IN_W-1:0] word);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Character-side back-pressure, with calm stretches of no stalls at all.
    initial begin
        int stall;
        bit calm;
        stall = 0;
        calm  = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 299) == 0) begin
                calm = ~calm;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm) begin
                    stall = pick_gap();
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("tb_integer_to_radix_digits NOT OK");
        $finish;
    end

    initial begin
        logic [63:0]        value;
        logic [RADIX_W-1:0] radix;
        int                 i;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corner conversions.
        send_request(pack_request(64'd0, 6'd10, 1'b0, 1'b0));
        send_request(pack_request(64'd0, 6'd2, 1'b1, 1'b1));
        send_request(pack_request({64{1'b1}}, 6'd2, 1'b0, 1'b0));
        send_request(pack_request({64{1'b1}}, 6'd10, 1'b0, 1'b1));
        send_request(pack_request({64{1'b1}}, 6'd10, 1'b1, 1'b0));
        send_request(pack_request({64{1'b1}}, 6'd2, 1'b1, 1'b0));
        send_request(pack_request(64'h8000_0000_0000_0000, 6'd10, 1'b1, 1'b0));
        send_request(pack_request(64'h8000_0000_0000_0000, 6'd16, 1'b1, 1'b1));
        send_request(pack_request(64'h8000_0000_0000_0000, 6'd2, 1'b1, 1'b0));
        send_request(pack_request(64'h8000_0000_0000_0000, 6'd10, 1'b0, 1'b0));
        send_request(pack_request(64'h7FFF_FFFF_FFFF_FFFF, 6'd10, 1'b1, 1'b1));
        send_request(pack_request(64'hFFFF_FFFF_FFFF_FF85, 6'd10, 1'b1, 1'b0));
        send_request(pack_request(64'hFFFF_FFFF_FFFF_FF85, 6'd3, 1'b1, 1'b1));
        send_request(pack_request(64'hDEAD_BEEF_CAFE_F00D, 6'd16, 1'b0, 1'b1));
        send_request(pack_request(64'hDEAD_BEEF_CAFE_F00D, 6'd16, 1'b0, 1'b0));
        send_request(pack_request({64{1'b1}}, 6'd36, 1'b0, 1'b1));
        send_request(pack_request(64'd1295, 6'd36, 1'b0, 1'b0));
        send_request(pack_request(64'd35, 6'd36, 1'b1, 1'b1));
        // Bases outside the legal range are clamped.
        send_request(pack_request(64'd5, 6'd0, 1'b0, 1'b0));
        send_request(pack_request(64'd5, 6'd1, 1'b1, 1'b0));
        send_request(pack_request(64'd1296, 6'd37, 1'b0, 1'b1));
        send_request(pack_request(64'hFFFF_FFFF_FFFF_FFD9, 6'd63, 1'b1, 1'b0));
        send_request(pack_request(64'd9, 6'd10, 1'b0, 1'b0));
        send_request(pack_request(64'd10, 6'd10, 1'b1, 1'b1));

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 20 == 0) begin
                src_calm = ($urandom_range(0, 3) == 0);
            end
            radix = ($urandom_range(0, 99) < 85) ? RADIX_W'($urandom_range(2, 36))
                                                 : RADIX_W'($urandom_range(0, 63));
            case ($urandom_range(0, 5))
                0: value = {$urandom, $urandom};
                1: value = 64'($urandom_range(0, 1000));
                2: value = {$urandom, $urandom} >> $urandom_range(0, 63);
                3: value = -64'($urandom_range(1, 1000));
                4: value = {1'b1, 63'({$urandom, $urandom} >> $urandom_range(0, 63))};
                default: begin
                    case ($urandom_range(0, 3))
                        0: value = 64'd0;
                        1: value = 64'h8000_0000_0000_0000;
                        2: value = {64{1'b1}};
                        default: value = 64'h7FFF_FFFF_FFFF_FFFF;
                    endcase
                end
            endcase
            send_request(pack_request(value, radix, 1'($urandom), 1'($urandom)));
        end
        s_axis_tvalid <= 1'b0;

        @(posedge aclk);
        while (chars_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0 && chars_outstanding == 0) begin
            $display("tb_integer_to_radix_digits OK");
        end else begin
            $display("tb_integer_to_radix_digits NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
design/itrd_pkg.sv
design/itrd_div.sv
design/itrd_dpath.sv
design/itrd_ctrl.sv
design/integer_to_radix_digits.sv
sim/itrd_checker.sv
sim/tb_integer_to_radix_digits.sv
